### rtl/gcdlcm_pkg.sv
package gcdlcm_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int FIELD_W       = 16;
    localparam int DIVISOR_W     = 16;
    localparam int MULTIPLE_W    = 32;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_STRIP,
        OP_NORM_X,
        OP_REDUCE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   publish;
    } cmd_t;

    typedef struct packed {
        logic zero_op;
        logic both_even;
        logic x_even;
        logic y_zero;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### rtl/gcdlcm_dp.sv
module gcdlcm_dp #(
    parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  gcdlcm_pkg::cmd_t                             cmd,
    output gcdlcm_pkg::status_t                          status,
    input  logic [gcdlcm_pkg::FIELD_W-1:0]               operand_a,
    input  logic [gcdlcm_pkg::FIELD_W-1:0]               operand_b,
    input  logic                                         out_ready,
    output logic                                         out_valid,
    output logic [gcdlcm_pkg::DIVISOR_W-1:0]             divisor_out,
    output logic [gcdlcm_pkg::MULTIPLE_W-1:0]            multiple_out,
    output logic                                         zero_error
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
    localparam int FW    = gcdlcm_pkg::FIELD_W;
    localparam int DW    = gcdlcm_pkg::DIVISOR_W;
    localparam int MW    = gcdlcm_pkg::MULTIPLE_W;

    logic [W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [W-1:0]     x_reg, x_next, y_reg, y_next;
    logic [W-1:0]     g_reg, g_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] sh_reg, sh_next, cnt_reg, cnt_next;
    logic [2*W-1:0]   prod_reg, prod_next;
    logic             zero_reg, zero_next;

    logic             out_valid_reg, out_valid_next;
    logic [DW-1:0]    out_div_reg, out_div_next;
    logic [MW-1:0]    out_mul_reg, out_mul_next;
    logic             out_err_reg, out_err_next;

    logic [W+FW-1:0]  a_wide, b_wide;
    logic [W:0]       rem_sh, diff;
    logic [W+DW-1:0]  g_ext;
    logic [2*W+MW-1:0] prod_ext;

    assign a_wide   = {{W{1'b0}}, operand_a};
    assign b_wide   = {{W{1'b0}}, operand_b};
    assign rem_sh   = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff     = rem_sh - {1'b0, g_reg};
    assign g_ext    = {{DW{1'b0}}, g_reg};
    assign prod_ext = {{MW{1'b0}}, prod_reg};

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        g_next    = g_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        zero_next = zero_reg;
        unique case (cmd.op)
            gcdlcm_pkg::OP_LOAD: begin
                a_next    = a_wide[W-1:0];
                b_next    = b_wide[W-1:0];
                x_next    = a_wide[W-1:0];
                y_next    = b_wide[W-1:0];
                sh_next   = '0;
                zero_next = (a_wide[W-1:0] == '0) || (b_wide[W-1:0] == '0);
            end
            gcdlcm_pkg::OP_STRIP: begin
                x_next  = x_reg >> 1;
                y_next  = y_reg >> 1;
                sh_next = sh_reg + 1'b1;
            end
            gcdlcm_pkg::OP_NORM_X: begin
                x_next = x_reg >> 1;
            end
            gcdlcm_pkg::OP_REDUCE: begin
                if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end else begin
                    y_next = y_reg - x_reg;
                end
            end
            gcdlcm_pkg::OP_DIV_INIT: begin
                g_next   = x_reg << sh_reg;
                quo_next = a_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            gcdlcm_pkg::OP_DIV_STEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (!diff[W]) begin
                    rem_next = diff;
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
            end
            gcdlcm_pkg::OP_MUL: begin
                prod_next = quo_reg * b_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_div_next   = out_div_reg;
        out_mul_next   = out_mul_reg;
        out_err_next   = out_err_reg;
        if (cmd.publish) begin
            out_valid_next = 1'b1;
            out_err_next   = zero_reg;
            out_div_next   = zero_reg ? '0 : g_ext[DW-1:0];
            out_mul_next   = zero_reg ? '0 : prod_ext[MW-1:0];
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        g_reg       <= g_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        sh_reg      <= sh_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        zero_reg    <= zero_next;
        out_div_reg <= out_div_next;
        out_mul_reg <= out_mul_next;
        out_err_reg <= out_err_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.zero_op   = zero_reg;
    assign status.both_even = !(x_reg[0] | y_reg[0]);
    assign status.x_even    = !x_reg[0];
    assign status.y_zero    = (y_reg == '0);
    assign status.div_last  = (cnt_reg == CNT_W'(W - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign divisor_out  = out_div_reg;
    assign multiple_out = out_mul_reg;
    assign zero_error   = out_err_reg;

endmodule

### rtl/gcdlcm_ctrl.sv
module gcdlcm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    output logic                req_ready,
    input  gcdlcm_pkg::status_t status,
    output gcdlcm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STRIP,
        S_NORM,
        S_REDUCE,
        S_DIV,
        S_MUL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.op      = gcdlcm_pkg::OP_NONE;
        cmd.publish = 1'b0;
        req_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.op     = gcdlcm_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = status.zero_op ? S_DONE : S_STRIP;
            end
            S_STRIP: begin
                if (status.both_even) begin
                    cmd.op = gcdlcm_pkg::OP_STRIP;
                end else begin
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (status.x_even) begin
                    cmd.op = gcdlcm_pkg::OP_NORM_X;
                end else begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (status.y_zero) begin
                    cmd.op     = gcdlcm_pkg::OP_DIV_INIT;
                    state_next = S_DIV;
                end else begin
                    cmd.op = gcdlcm_pkg::OP_REDUCE;
                end
            end
            S_DIV: begin
                cmd.op = gcdlcm_pkg::OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.op     = gcdlcm_pkg::OP_MUL;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/gcd_lcm_unit.sv
// GCD / LCM unit. Each request carries two unsigned operands (low OPERAND_WIDTH
// bits of each field used) and yields one result: the greatest common divisor
// (low 16 bits) and least common multiple (low 32 bits). If either operand is
// zero, m_axis_tuser is set and both values are zero. One request at a time:
// binary GCD runs one shift or subtract per cycle; every subtract but the last is
// followed by a shift, and shifts are bounded by the 2*W operand bits (W =
// OPERAND_WIDTH). A restoring divider then forms a/gcd, a multiply of the
// quotient by the second operand gives the LCM, and a zero operand skips
// straight to the result.
// A new request is taken while the previous result waits on m_axis.
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = gcdlcm_pkg::OPERAND_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] operand_a, [31:16] operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] divisor_out, [47:16] multiple_out
    output logic [0:0]  m_axis_tuser    // [0] zero_error
);

    gcdlcm_pkg::cmd_t    cmd;
    gcdlcm_pkg::status_t status;
    logic [gcdlcm_pkg::DIVISOR_W-1:0]  divisor_out;
    logic [gcdlcm_pkg::MULTIPLE_W-1:0] multiple_out;
    logic                              zero_error;

    gcdlcm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    gcdlcm_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .operand_a    (s_axis_tdata[15:0]),
        .operand_b    (s_axis_tdata[31:16]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .divisor_out  (divisor_out),
        .multiple_out (multiple_out),
        .zero_error   (zero_error)
    );

    assign m_axis_tdata = {multiple_out, divisor_out};
    assign m_axis_tuser = zero_error;

endmodule

### tb/sv/testbench.sv
module testbench;

    localparam int OPW          = gcdlcm_pkg::OPERAND_WIDTH;
    localparam int FW           = gcdlcm_pkg::FIELD_W;
    localparam int DVW          = gcdlcm_pkg::DIVISOR_W;
    localparam int MLW          = gcdlcm_pkg::MULTIPLE_W;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 3 * OPW + 20;
    localparam int PHASE_ITEMS  = 400;
    localparam int REPORT_MAX   = 10;
    localparam int N_DIRECTED   = 22;

    typedef struct packed {
        logic [DVW-1:0] divisor;
        logic [MLW-1:0] multiple;
        logic           zero_err;
    } gcd_result_t;

    typedef struct packed {
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        logic          typed;
        gcd_result_t   res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    gcd_result_t pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    stim_row_t   directed_rows [0:N_DIRECTED-1];

    gcd_lcm_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic gcd_result_t gcd_lcm_of(input logic [FW-1:0] a_in,
                                               input logic [FW-1:0] b_in);
        longint unsigned mask;
        longint unsigned oa;
        longint unsigned ob;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        longint unsigned g;
        longint unsigned lcm;
        int unsigned     twos;
        gcd_result_t     r;
        mask = (64'd1 << OPW) - 64'd1;
        oa = a_in & mask;
        ob = b_in & mask;
        r = '0;
        if (oa == 0 || ob == 0) begin
            r.zero_err = 1'b1;
            return r;
        end
        x = oa;
        y = ob;
        twos = 0;
        while (((x | y) & 64'd1) == 0) begin
            x = x >> 1;
            y = y >> 1;
            twos++;
        end
        while ((x & 64'd1) == 0)
            x = x >> 1;
        while (y != 0) begin
            while ((y & 64'd1) == 0)
                y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        g = x << twos;
        lcm = (oa / g) * ob;
        r.divisor = g[DVW-1:0];
        r.multiple = lcm[MLW-1:0];
        return r;
    endfunction

    task automatic random_operands(output logic [FW-1:0] a,
                                   output logic [FW-1:0] b);
        int unsigned mode;
        int unsigned g;
        mode = $urandom_range(99);
        if (mode < 40) begin
            a = FW'($urandom);
            b = FW'($urandom);
        end else if (mode < 65) begin
            // shared factor so the divisor is large
            g = $urandom_range(2, 4095);
            a = FW'(g * $urandom_range(1, 65535 / g));
            b = FW'(g * $urandom_range(1, 65535 / g));
        end else if (mode < 78) begin
            a = FW'($urandom_range(1, 64));
            b = FW'($urandom_range(1, 64));
        end else if (mode < 88) begin
            a = 16'd1 << $urandom_range(0, 15);
            b = FW'($urandom);
            if ($urandom_range(1))
                b = b << $urandom_range(0, 12);
        end else if (mode < 94) begin
            a = FW'($urandom);
            b = a;
        end else begin
            a = FW'($urandom);
            b = FW'($urandom);
            case ($urandom_range(2))
                0: a = '0;
                1: b = '0;
                default: begin
                    a = '0;
                    b = '0;
                end
            endcase
        end
    endtask

    task automatic send_request(input logic [FW-1:0] a, input logic [FW-1:0] b,
                                input logic typed, input gcd_result_t typed_res);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(),
                               typed ? typed_res : gcd_lcm_of(a, b));
    endtask

    task automatic wait_all_results;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic check_result(input gcd_result_t got);
        gcd_result_t want;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("unexpected result: gcd=%h lcm=%h err=%b",
                         got.divisor, got.multiple, got.zero_err);
            return;
        end
        want = pending_results.pop_front();
        if (got.divisor !== want.divisor || got.multiple !== want.multiple ||
            got.zero_err !== want.zero_err) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch: expected gcd=%h lcm=%h err=%b, got gcd=%h lcm=%h err=%b",
                         want.divisor, want.multiple, want.zero_err,
                         got.divisor, got.multiple, got.zero_err);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            check_result({m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tuser[0]});
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [FW-1:0] a;
        logic [FW-1:0] b;
        int            phase_idle [4];
        int            phase_stall [4];

        // zero operand -> error flag, both values zero
        directed_rows[0]  = '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}};
        directed_rows[1]  = '{16'h0000, 16'h1234, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}};
        directed_rows[2]  = '{16'hABCD, 16'h0000, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}};
        directed_rows[3]  = '{16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}};
        directed_rows[4]  = '{16'hFFFF, 16'h0000, 1'b1, '{16'h0000, 32'h0000_0000, 1'b1}};
        // equal operands and extremes
        directed_rows[5]  = '{16'h0001, 16'h0001, 1'b1, '{16'h0001, 32'h0000_0001, 1'b0}};
        directed_rows[6]  = '{16'h0001, 16'hFFFF, 1'b1, '{16'h0001, 32'h0000_FFFF, 1'b0}};
        directed_rows[7]  = '{16'hFFFF, 16'h0001, 1'b1, '{16'h0001, 32'h0000_FFFF, 1'b0}};
        directed_rows[8]  = '{16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 32'h0000_FFFF, 1'b0}};
        directed_rows[9]  = '{16'h8000, 16'h8000, 1'b1, '{16'h8000, 32'h0000_8000, 1'b0}};
        directed_rows[10] = '{16'hFFFF, 16'hFFFE, 1'b1, '{16'h0001, 32'hFFFD_0002, 1'b0}};
        directed_rows[11] = '{16'hFFFE, 16'hFFFF, 1'b1, '{16'h0001, 32'hFFFD_0002, 1'b0}};
        directed_rows[12] = '{16'h8000, 16'h0001, 1'b1, '{16'h0001, 32'h0000_8000, 1'b0}};
        directed_rows[13] = '{16'h5555, 16'hAAAA, 1'b1, '{16'h5555, 32'h0000_AAAA, 1'b0}};
        directed_rows[14] = '{16'h000C, 16'h0012, 1'b0, '0};
        directed_rows[15] = '{16'h0007, 16'h000D, 1'b0, '0};
        directed_rows[16] = '{16'h8000, 16'hFFFE, 1'b0, '0};
        directed_rows[17] = '{16'hFFF0, 16'h0F00, 1'b0, '0};
        directed_rows[18] = '{16'hAAAA, 16'h5555, 1'b0, '0};
        directed_rows[19] = '{16'h1000, 16'h0010, 1'b0, '0};
        directed_rows[20] = '{16'hFFFE, 16'hFFFC, 1'b0, '0};
        directed_rows[21] = '{16'hFFF1, 16'h7FFF, 1'b0, '0};

        phase_idle  = '{0, 74, 0, 22};
        phase_stall = '{0, 0, 74, 22};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].a, directed_rows[i].b,
                         directed_rows[i].typed, directed_rows[i].res);
        s_axis_tvalid <= 1'b0;
        wait_all_results();

        for (int p = 0; p < 4; p++) begin
            idle_pct = phase_idle[p];
            stall_pct <= phase_stall[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long output hold-off while requests keep coming
                if (p == 0 && n == 100)
                    hold_requests <= hold_requests + 1;
                random_operands(a, b);
                send_request(a, b, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
rtl/gcdlcm_pkg.sv
rtl/gcdlcm_dp.sv
rtl/gcdlcm_ctrl.sv
rtl/gcd_lcm_unit.sv
tb/sv/testbench.sv
